// ===== src/bitmap_page_frame_allocator_top_defines.svh =====
// assertion macros for the bitmap page frame allocator
// used by bitmap_page_frame_allocator_top; expects clk_i and rst_ni in scope
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BPFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bpfa_pkg.sv =====
// shared types and constants for the bitmap page frame allocator
// no dependencies
package bpfa_pkg;

  localparam int PAGE_COUNT_DEF = 1024;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam int WORD_BITS    = 32;
  localparam int WORD_IDX_W   = 5;
  localparam int ADDR_W       = 32;
  localparam int PAGE_INDEX_W = 10;
  localparam int RES_FIRST_W  = 10;
  localparam int RES_COUNT_W  = 11;
  localparam int REQ_W        = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int CMP_W        = 17;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_INIT  = 2'd2
  } req_type_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MEMORY_BASE = 2'd0,
    REG_RES_FIRST   = 2'd1,
    REG_RES_COUNT   = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_ALLOC = 4'b0100,
    ST_FREE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctl_t;

endpackage

// ===== src/bpfa_bitmap_ram.sv =====
// used-bit store, one word of page bits per entry, registered read
// depends on bpfa_pkg
module bpfa_bitmap_ram #(
  parameter int NUM_WORDS = bpfa_pkg::PAGE_COUNT_DEF / bpfa_pkg::WORD_BITS,
  parameter int WORD_AW   = 5
) (
  input  logic                           clk_i,
  input  bpfa_pkg::ram_ctl_t             ctl_i,
  input  logic [WORD_AW-1:0]             addr_i,
  input  logic [bpfa_pkg::WORD_BITS-1:0] wdata_i,
  output logic [bpfa_pkg::WORD_BITS-1:0] rdata_o
);

  logic [bpfa_pkg::WORD_BITS-1:0] mem_q [NUM_WORDS];
  logic [bpfa_pkg::WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bpfa_find_free.sv =====
// lowest clear bit of one bitmap word
// depends on bpfa_pkg
module bpfa_find_free (
  input  logic [bpfa_pkg::WORD_BITS-1:0]  word_i,
  output logic                            found_o,
  output logic [bpfa_pkg::WORD_IDX_W-1:0] bit_o
);

  always_comb begin
    bit_o = '0;
    for (int j = bpfa_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (!word_i[j]) begin
        bit_o = bpfa_pkg::WORD_IDX_W'(j);
      end
    end
  end

  assign found_o = ~&word_i;

endmodule

// ===== src/bitmap_page_frame_allocator_top.sv =====
// bitmap page frame allocator, first fit, top level
// depends on bpfa_pkg, bpfa_bitmap_ram, bpfa_find_free and the defines header
//
// requests: start with req_type_i and page_index_i, taken when start is high
//   and busy is low. 0 allocates the lowest free page, 1 frees page_index_i,
//   2 re-initialises the map and marks the configured reserved run as used.
// results: one per request, shown for one cycle with done_o high; there is
//   no back-pressure, the receiver must take it in that cycle.
// config: cfg_valid_i / cfg_ready_o beats with cfg_index_i and cfg_data_i;
//   ready is always high. write only while busy is low and no result pending.
// operation (W = words of 32 pages, 32 by default):
//   free: reads the page's word, then writes it back with the bit cleared
//   allocate: reads words upward from a low-water word pointer until one holds a clear bit and sets it,
//     or fails at the last word; the pointer keeps the search short after the first fill
//   init: one word written per cycle over all W words through the single ram port
//   unknown request or out of range free: result in the next cycle
// reset: the map is swept to all free, one word per cycle over all W words, with
//   busy high; configuration beats are still taken during the sweep.
module bitmap_page_frame_allocator_top #(
  parameter int PAGE_COUNT = bpfa_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [bpfa_pkg::REQ_W-1:0]        req_type_i,
  input  logic [bpfa_pkg::PAGE_INDEX_W-1:0] page_index_i,
  output logic                              done_o,
  output logic                              success_o,
  output logic [bpfa_pkg::ADDR_W-1:0]       page_address_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bpfa_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  `include "bitmap_page_frame_allocator_top_defines.svh"

  localparam int NUM_WORDS = (PAGE_COUNT + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PG_W      = WORD_AW + bpfa_pkg::WORD_IDX_W;
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);
  localparam logic [bpfa_pkg::CMP_W-1:0] PAGE_LIMIT = bpfa_pkg::CMP_W'(PAGE_COUNT);

  bpfa_pkg::state_e state_q, state_d;
  logic [WORD_AW-1:0] word_q, word_d;
  logic [WORD_AW-1:0] hint_q, hint_d;
  logic [bpfa_pkg::WORD_IDX_W-1:0] bit_q, bit_d;
  logic sweep_init_q, sweep_init_d;
  logic done_q, done_d;
  logic success_q, success_d;
  logic [bpfa_pkg::ADDR_W-1:0] page_address_q, page_address_d;
  logic [bpfa_pkg::ADDR_W-1:0] base_q;
  logic [bpfa_pkg::RES_FIRST_W-1:0] res_first_q;
  logic [bpfa_pkg::RES_COUNT_W-1:0] res_count_q;

  bpfa_pkg::ram_ctl_t ram_ctl;
  logic [WORD_AW-1:0] ram_addr;
  logic [bpfa_pkg::WORD_BITS-1:0] ram_wdata;
  logic [bpfa_pkg::WORD_BITS-1:0] ram_rdata;
  logic [bpfa_pkg::WORD_BITS-1:0] clear_word;
  logic [bpfa_pkg::CMP_W-1:0] res_lo;
  logic [bpfa_pkg::CMP_W-1:0] res_hi;
  logic [bpfa_pkg::CMP_W-1:0] free_page;
  logic [WORD_AW-1:0] free_word;
  logic [WORD_AW-1:0] word_next;
  logic free_in_range;
  logic found;
  logic [bpfa_pkg::WORD_IDX_W-1:0] found_bit;
  logic [PG_W-1:0] alloc_page;

  bpfa_bitmap_ram #(
    .NUM_WORDS (NUM_WORDS),
    .WORD_AW   (WORD_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  bpfa_find_free u_find (
    .word_i  (ram_rdata),
    .found_o (found),
    .bit_o   (found_bit)
  );

  // reserved run and padding past the last page, one word at a time
  assign res_lo = bpfa_pkg::CMP_W'(res_first_q);
  assign res_hi = bpfa_pkg::CMP_W'(res_first_q) + bpfa_pkg::CMP_W'(res_count_q);

  always_comb begin
    logic [bpfa_pkg::CMP_W-1:0] p;
    for (int j = 0; j < bpfa_pkg::WORD_BITS; j++) begin
      p = bpfa_pkg::CMP_W'({word_q, bpfa_pkg::WORD_IDX_W'(j)});
      clear_word[j] = (p >= PAGE_LIMIT) || (sweep_init_q && (p >= res_lo) && (p < res_hi));
    end
  end

  assign free_page     = bpfa_pkg::CMP_W'(page_index_i);
  assign free_in_range = free_page < PAGE_LIMIT;
  assign free_word     = WORD_AW'(page_index_i[bpfa_pkg::PAGE_INDEX_W-1:bpfa_pkg::WORD_IDX_W]);
  assign word_next     = WORD_AW'(word_q + 1'b1);
  assign alloc_page    = {word_q, found_bit};

  always_comb begin
    state_d        = state_q;
    word_d         = word_q;
    hint_d         = hint_q;
    bit_d          = bit_q;
    sweep_init_d   = sweep_init_q;
    done_d         = 1'b0;
    success_d      = success_q;
    page_address_d = page_address_q;
    ram_ctl        = '0;
    ram_addr       = word_q;
    ram_wdata      = clear_word;
    unique case (state_q)
      bpfa_pkg::ST_IDLE: begin
        if (start) begin
          case (req_type_i)
            bpfa_pkg::REQ_ALLOC: begin
              ram_ctl.rd_en = 1'b1;
              ram_addr      = hint_q;
              word_d        = hint_q;
              state_d       = bpfa_pkg::ST_ALLOC;
            end
            bpfa_pkg::REQ_FREE: begin
              if (free_in_range) begin
                ram_ctl.rd_en = 1'b1;
                ram_addr      = free_word;
                word_d        = free_word;
                bit_d         = page_index_i[bpfa_pkg::WORD_IDX_W-1:0];
                state_d       = bpfa_pkg::ST_FREE;
              end else begin
                done_d         = 1'b1;
                success_d      = 1'b0;
                page_address_d = '0;
              end
            end
            bpfa_pkg::REQ_INIT: begin
              word_d       = '0;
              sweep_init_d = 1'b1;
              state_d      = bpfa_pkg::ST_CLEAR;
            end
            default: begin
              done_d         = 1'b1;
              success_d      = 1'b0;
              page_address_d = '0;
            end
          endcase
        end
      end
      bpfa_pkg::ST_CLEAR: begin
        ram_ctl.wr_en = 1'b1;
        if (word_q == LAST_WORD) begin
          state_d = bpfa_pkg::ST_IDLE;
          hint_d  = '0;
          if (sweep_init_q) begin
            done_d         = 1'b1;
            success_d      = 1'b1;
            page_address_d = '0;
          end
        end else begin
          word_d = word_next;
        end
      end
      bpfa_pkg::ST_ALLOC: begin
        if (found) begin
          ram_ctl.wr_en  = 1'b1;
          ram_wdata      = ram_rdata | (bpfa_pkg::WORD_BITS'(1) << found_bit);
          done_d         = 1'b1;
          success_d      = 1'b1;
          page_address_d = base_q + (bpfa_pkg::ADDR_W'(alloc_page) << PAGE_SHIFT);
          state_d        = bpfa_pkg::ST_IDLE;
        end else if (word_q == LAST_WORD) begin
          done_d         = 1'b1;
          success_d      = 1'b0;
          page_address_d = '0;
          state_d        = bpfa_pkg::ST_IDLE;
        end else begin
          // every word up to here is full
          ram_ctl.rd_en = 1'b1;
          ram_addr      = word_next;
          word_d        = word_next;
          hint_d        = word_next;
        end
      end
      bpfa_pkg::ST_FREE: begin
        ram_ctl.wr_en  = 1'b1;
        ram_wdata      = ram_rdata & ~(bpfa_pkg::WORD_BITS'(1) << bit_q);
        done_d         = 1'b1;
        success_d      = 1'b1;
        page_address_d = '0;
        if (word_q < hint_q) begin
          hint_d = word_q;
        end
        state_d = bpfa_pkg::ST_IDLE;
      end
      default: begin
        state_d = bpfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bpfa_pkg::ST_CLEAR;
      word_q       <= '0;
      hint_q       <= '0;
      sweep_init_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      word_q       <= word_d;
      hint_q       <= hint_d;
      sweep_init_q <= sweep_init_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q          <= bit_d;
    success_q      <= success_d;
    page_address_q <= page_address_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      res_first_q <= '0;
      res_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bpfa_pkg::REG_MEMORY_BASE: base_q      <= cfg_data_i;
        bpfa_pkg::REG_RES_FIRST:   res_first_q <= cfg_data_i[bpfa_pkg::RES_FIRST_W-1:0];
        bpfa_pkg::REG_RES_COUNT:   res_count_q <= cfg_data_i[bpfa_pkg::RES_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign busy           = (state_q != bpfa_pkg::ST_IDLE);
  assign done_o         = done_q;
  assign success_o      = success_q;
  assign page_address_o = page_address_q;

  `BPFA_ASSERT_NXT(a_accept_progress, start && !busy, busy || done_o, "accepted beat made no progress")
  `BPFA_ASSERT_IMP(a_done_after_work, done_o, $past(busy || start), "result without a request")
  `BPFA_ASSERT_IMP(a_ram_one_access, ram_ctl.rd_en, !ram_ctl.wr_en, "ram read and write together")
  `BPFA_ASSERT_IMP(a_fail_zero_addr, done_o && !success_o, page_address_o == '0, "failed request with address")

endmodule

// ===== sim/bitmap_page_frame_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for bitmap_page_frame_allocator_top: directed and random requests
// depends on bpfa_pkg and the allocator rtl; results are predicted from a local page map
module bitmap_page_frame_allocator_top_tb;

  localparam int NUM_PAGES = bpfa_pkg::PAGE_COUNT_DEF;
  localparam int PG_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF;
  localparam logic [bpfa_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 64;

  typedef enum logic [1:0] {ITEM_REQ, ITEM_CFG, ITEM_PHASE} item_kind_e;

  typedef struct {
    item_kind_e kind;
    logic [bpfa_pkg::REQ_W-1:0] req;
    logic [bpfa_pkg::PAGE_INDEX_W-1:0] page;
    bpfa_pkg::cfg_reg_e reg_sel;
    logic [bpfa_pkg::CFG_DATA_W-1:0] data;
    int unsigned idle_pct;
  } frame_item_t;

  typedef struct {
    logic success;
    logic [bpfa_pkg::ADDR_W-1:0] addr;
  } frame_outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [bpfa_pkg::REQ_W-1:0] req_type_i = bpfa_pkg::REQ_ALLOC;
  logic [bpfa_pkg::PAGE_INDEX_W-1:0] page_index_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [bpfa_pkg::CFG_INDEX_W-1:0] cfg_index_i = bpfa_pkg::REG_MEMORY_BASE;
  logic [bpfa_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic busy, done_o, success_o, cfg_ready_o;
  logic [bpfa_pkg::ADDR_W-1:0] page_address_o;

  frame_item_t pending_q[$];
  frame_outcome_t expected_outcome_q[$];

  logic [NUM_PAGES-1:0] page_used = '0;
  logic [bpfa_pkg::ADDR_W-1:0] mem_base = '0;
  logic [bpfa_pkg::RES_FIRST_W-1:0] res_first = '0;
  logic [bpfa_pkg::RES_COUNT_W-1:0] res_count = '0;
  int unsigned idle_pct = 0;

  int unsigned n_alloc = 0, n_full = 0, n_free = 0, n_init = 0, n_unknown = 0;
  int unsigned n_cfg = 0, n_results = 0, n_errors = 0;

  bitmap_page_frame_allocator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .page_index_i  (page_index_i),
    .done_o        (done_o),
    .success_o     (success_o),
    .page_address_o(page_address_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // first fit search, free, init over the local page map
  function automatic frame_outcome_t predict_frame_request(
      logic [bpfa_pkg::REQ_W-1:0] kind, logic [bpfa_pkg::PAGE_INDEX_W-1:0] page);
    frame_outcome_t o;
    logic found;
    int p;
    o.success = 1'b0;
    o.addr = '0;
    found = 1'b0;
    case (kind)
      bpfa_pkg::REQ_ALLOC: begin
        n_alloc++;
        for (int i = 0; i < NUM_PAGES; i++) begin
          if (!found && !page_used[i]) begin
            found = 1'b1;
            page_used[i] = 1'b1;
            o.success = 1'b1;
            o.addr = mem_base + (bpfa_pkg::ADDR_W'(i) << PG_SHIFT);
          end
        end
        if (!found) n_full++;
      end
      bpfa_pkg::REQ_FREE: begin
        n_free++;
        if (int'(page) < NUM_PAGES) begin
          page_used[page] = 1'b0;
          o.success = 1'b1;
        end
      end
      bpfa_pkg::REQ_INIT: begin
        n_init++;
        page_used = '0;
        for (int k = 0; k < int'(res_count); k++) begin
          p = int'(res_first) + k;
          if (p < NUM_PAGES) page_used[p] = 1'b1;
        end
        o.success = 1'b1;
      end
      default: n_unknown++;
    endcase
    return o;
  endfunction

  function automatic void apply_register_write(logic [bpfa_pkg::CFG_INDEX_W-1:0] sel,
                                               logic [bpfa_pkg::CFG_DATA_W-1:0] data);
    n_cfg++;
    case (sel)
      bpfa_pkg::REG_MEMORY_BASE: mem_base = data;
      bpfa_pkg::REG_RES_FIRST:   res_first = data[bpfa_pkg::RES_FIRST_W-1:0];
      bpfa_pkg::REG_RES_COUNT:   res_count = data[bpfa_pkg::RES_COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic push_req(logic [bpfa_pkg::REQ_W-1:0] req,
                          logic [bpfa_pkg::PAGE_INDEX_W-1:0] page);
    frame_item_t it;
    it = '{kind: ITEM_REQ, req: req, page: page, reg_sel: bpfa_pkg::REG_MEMORY_BASE,
           data: '0, idle_pct: 0};
    pending_q.push_back(it);
  endtask

  task automatic push_cfg(bpfa_pkg::cfg_reg_e sel, logic [bpfa_pkg::CFG_DATA_W-1:0] data);
    frame_item_t it;
    it = '{kind: ITEM_CFG, req: bpfa_pkg::REQ_ALLOC, page: '0, reg_sel: sel, data: data,
           idle_pct: 0};
    pending_q.push_back(it);
  endtask

  task automatic push_phase(int unsigned pct);
    frame_item_t it;
    it = '{kind: ITEM_PHASE, req: bpfa_pkg::REQ_ALLOC, page: '0,
           reg_sel: bpfa_pkg::REG_MEMORY_BASE, data: '0, idle_pct: pct};
    pending_q.push_back(it);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : frame_driver
    logic hold_req, hold_cfg;
    logic [bpfa_pkg::REQ_W-1:0] nxt_req;
    logic [bpfa_pkg::PAGE_INDEX_W-1:0] nxt_page;
    logic [bpfa_pkg::CFG_INDEX_W-1:0] nxt_sel;
    logic [bpfa_pkg::CFG_DATA_W-1:0] nxt_data;
    frame_item_t it;
    if (!rst_ni) begin
      start <= 1'b0;
      req_type_i <= bpfa_pkg::REQ_ALLOC;
      page_index_i <= '0;
      cfg_valid_i <= 1'b0;
      cfg_index_i <= bpfa_pkg::REG_MEMORY_BASE;
      cfg_data_i <= '0;
    end else begin
      hold_req = start;
      hold_cfg = cfg_valid_i;
      nxt_req = req_type_i;
      nxt_page = page_index_i;
      nxt_sel = cfg_index_i;
      nxt_data = cfg_data_i;
      if (start && !busy) begin
        expected_outcome_q.push_back(predict_frame_request(req_type_i, page_index_i));
        hold_req = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_register_write(cfg_index_i, cfg_data_i);
        hold_cfg = 1'b0;
      end
      if (!hold_req && !hold_cfg && pending_q.size() != 0) begin
        it = pending_q[0];
        case (it.kind)
          ITEM_PHASE: begin
            idle_pct = it.idle_pct;
            void'(pending_q.pop_front());
          end
          ITEM_CFG: begin
            // register writes only once the block is idle
            if (!busy && expected_outcome_q.size() == 0) begin
              hold_cfg = 1'b1;
              nxt_sel = it.reg_sel;
              nxt_data = it.data;
              void'(pending_q.pop_front());
            end
          end
          default: begin
            if ($urandom_range(0, 99) >= idle_pct) begin
              hold_req = 1'b1;
              nxt_req = it.req;
              nxt_page = it.page;
              void'(pending_q.pop_front());
            end
          end
        endcase
      end
      start <= hold_req;
      req_type_i <= nxt_req;
      page_index_i <= nxt_page;
      cfg_valid_i <= hold_cfg;
      cfg_index_i <= nxt_sel;
      cfg_data_i <= nxt_data;
    end
  end

  always @(posedge clk_i) begin : outcome_monitor
    frame_outcome_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_outcome_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got success %0b address %08h",
                 $time, success_o, page_address_o);
        n_errors++;
      end else begin
        want = expected_outcome_q.pop_front();
        if (success_o !== want.success) begin
          $display("%0t: success mismatch, expected %0b, got %0b",
                   $time, want.success, success_o);
          n_errors++;
        end
        if (page_address_o !== want.addr) begin
          $display("%0t: page_address mismatch, expected %08h, got %08h",
                   $time, want.addr, page_address_o);
          n_errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned n_random, seg_len, first, cnt, r, phase, cur_phase;
    int unsigned phase_idle[4];
    logic [bpfa_pkg::CFG_DATA_W-1:0] base;
    logic [bpfa_pkg::PAGE_INDEX_W-1:0] page;
    phase_idle = '{0, 49, 21, 0};

    // directed part
    push_phase(0);
    push_cfg(bpfa_pkg::REG_MEMORY_BASE, 32'hFFFF_F000);
    push_req(bpfa_pkg::REQ_ALLOC, 10'h000);
    push_req(bpfa_pkg::REQ_ALLOC, 10'h3FF);
    push_req(bpfa_pkg::REQ_FREE, 10'h000);
    push_req(bpfa_pkg::REQ_FREE, 10'h000);
    push_req(bpfa_pkg::REQ_ALLOC, 10'h155);
    push_req(bpfa_pkg::REQ_FREE, 10'h3FF);
    push_req(REQ_UNKNOWN, 10'h3FF);
    push_req(bpfa_pkg::REQ_INIT, 10'h2AA);
    push_cfg(bpfa_pkg::REG_MEMORY_BASE, 32'hFFFF_FFFF);
    push_req(bpfa_pkg::REQ_ALLOC, 10'h2AA);
    push_cfg(bpfa_pkg::REG_RES_FIRST, 32'd0);
    push_cfg(bpfa_pkg::REG_RES_COUNT, 32'd1024);
    push_req(bpfa_pkg::REQ_INIT, 10'h000);
    push_req(bpfa_pkg::REQ_ALLOC, 10'h000);
    push_req(bpfa_pkg::REQ_FREE, 10'h3FF);
    push_req(bpfa_pkg::REQ_ALLOC, 10'h000);
    push_req(bpfa_pkg::REQ_ALLOC, 10'h000);
    push_cfg(bpfa_pkg::REG_MEMORY_BASE, 32'h0000_0000);
    push_cfg(bpfa_pkg::REG_RES_FIRST, 32'd1023);
    push_req(bpfa_pkg::REQ_INIT, 10'h000);
    push_req(bpfa_pkg::REQ_ALLOC, 10'h000);
    push_cfg(bpfa_pkg::REG_RES_FIRST, 32'd1);
    push_cfg(bpfa_pkg::REG_RES_COUNT, 32'd1023);
    push_req(bpfa_pkg::REQ_INIT, 10'h000);
    push_req(bpfa_pkg::REQ_ALLOC, 10'h000);
    push_req(bpfa_pkg::REQ_ALLOC, 10'h000);
    push_cfg(bpfa_pkg::REG_RES_COUNT, 32'd0);
    push_req(bpfa_pkg::REQ_INIT, 10'h000);

    // random segments: new settings, init, then a burst of requests
    n_random = 0;
    cur_phase = 4;
    while (n_random < RANDOM_ITEMS) begin
      phase = (n_random * 4) / RANDOM_ITEMS;
      if (phase != cur_phase) begin
        cur_phase = phase;
        push_phase(phase_idle[phase]);
      end
      case ($urandom_range(0, 3))
        0: begin
          first = $urandom_range(0, 6);
          cnt = NUM_PAGES;
        end
        1: begin
          first = $urandom_range(0, NUM_PAGES - 1);
          cnt = $urandom_range(0, NUM_PAGES);
        end
        2: begin
          first = $urandom_range(900, NUM_PAGES - 1);
          cnt = $urandom_range(100, NUM_PAGES);
        end
        default: begin
          first = $urandom_range(0, NUM_PAGES - 1);
          cnt = $urandom_range(0, 8);
        end
      endcase
      case ($urandom_range(0, 3))
        0: base = 32'h0000_0000;
        1: base = 32'hFFFF_FFFF;
        default: base = $urandom;
      endcase
      push_cfg(bpfa_pkg::REG_MEMORY_BASE, base);
      push_cfg(bpfa_pkg::REG_RES_FIRST, first);
      push_cfg(bpfa_pkg::REG_RES_COUNT, cnt);
      push_req(bpfa_pkg::REQ_INIT, bpfa_pkg::PAGE_INDEX_W'($urandom));
      seg_len = $urandom_range(10, 40);
      for (int j = 0; j < int'(seg_len); j++) begin
        r = $urandom_range(0, 99);
        page = bpfa_pkg::PAGE_INDEX_W'($urandom);
        if (r < 55) begin
          push_req(bpfa_pkg::REQ_ALLOC, page);
        end else if (r < 88) begin
          // half of them forced to low pages, where first fit lands
          if ($urandom_range(0, 1) == 0) page = bpfa_pkg::PAGE_INDEX_W'($urandom_range(0, 47));
          push_req(bpfa_pkg::REQ_FREE, page);
        end else if (r < 94) begin
          push_req(REQ_UNKNOWN, page);
        end else begin
          push_req(bpfa_pkg::REQ_INIT, page);
        end
      end
      n_random += seg_len + 1;
    end

    while (pending_q.size() != 0 || start || cfg_valid_i || expected_outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_outcome_q.size() != 0) begin
      $display("%0t: outstanding results, expected 0, got %0d",
               $time, expected_outcome_q.size());
      n_errors++;
    end

    $display("covered %0d allocations (%0d on a full map), %0d frees, %0d inits, %0d unknown",
             n_alloc, n_full, n_free, n_init, n_unknown);
    $display("%0d register writes, %0d result beats checked, %0d mismatches",
             n_cfg, n_results, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== bitmap_page_frame_allocator_top.f =====
+incdir+src
src/bpfa_pkg.sv
src/bpfa_bitmap_ram.sv
src/bpfa_find_free.sv
src/bitmap_page_frame_allocator_top.sv
sim/bitmap_page_frame_allocator_top_tb.sv
